FILE: design/lbcp_pkg.sv
// ----------------------------------------------------------------------------
// lbcp_pkg
// Shared types and constants for the status lamp blink-code pipeline.
// ----------------------------------------------------------------------------
package lbcp_pkg;

  localparam int NOW_W        = 32;
  localparam int STATE_W      = 3;
  localparam int FAULT_W      = 5;
  localparam int MS_W         = 16;
  localparam int CFG_ADDR_W   = 2;
  localparam int BLIP_W       = 5;
  localparam int SLOT_W       = MS_W + 1;
  localparam int SPAN_W       = 22;
  localparam int REM_STEPS    = 4;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_BLIP_ON  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLIP_OFF = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAP      = 2'd2;

  localparam logic [MS_W-1:0] BLIP_ON_RST  = 16'd150;
  localparam logic [MS_W-1:0] BLIP_OFF_RST = 16'd250;
  localparam logic [MS_W-1:0] GAP_RST      = 16'd1200;

  localparam logic [STATE_W-1:0] ST_INIT     = 3'd0;
  localparam logic [STATE_W-1:0] ST_SELFTEST = 3'd1;
  localparam logic [STATE_W-1:0] ST_READY    = 3'd2;
  localparam logic [STATE_W-1:0] ST_RUN      = 3'd3;

  localparam logic [BLIP_W-1:0] BLIPS_ONE = 5'd1;
  localparam logic [BLIP_W-1:0] BLIPS_TWO = 5'd2;

  typedef struct packed {
    logic              force_on;
    logic              pattern;
    logic [BLIP_W-1:0] blips;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   gap_ms;
    logic [SPAN_W-1:0] lit_span;
    logic [SPAN_W-1:0] cycle;
    logic [SPAN_W-1:0] rem;
  } ctl_t;

endpackage

FILE: design/lbcp_in_if.sv
// ----------------------------------------------------------------------------
// lbcp_in_if
// Input item channel: timestamp, drive state and fault code.
// ----------------------------------------------------------------------------
interface lbcp_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbcp_pkg::NOW_W-1:0]   now_ms;
  logic [lbcp_pkg::STATE_W-1:0] drive_state;
  logic [lbcp_pkg::FAULT_W-1:0] fault_code;

  modport source (output valid, output now_ms, output drive_state, output fault_code,
                  input ready);
  modport sink (input valid, input now_ms, input drive_state, input fault_code,
                output ready);
endinterface

FILE: design/lbcp_out_if.sv
// ----------------------------------------------------------------------------
// lbcp_out_if
// Result item channel: status lamp level.
// ----------------------------------------------------------------------------
interface lbcp_out_if;
  logic valid;
  logic ready;
  logic lamp_on;

  modport source (output valid, output lamp_on, input ready);
  modport sink (input valid, input lamp_on, output ready);
endinterface

FILE: design/lbcp_rem_stage.sv
// ----------------------------------------------------------------------------
// lbcp_rem_stage
// One registered stage of the restoring remainder of the timestamp by the
// pattern cycle length; handles STEPS timestamp bits, MSB first.
// ----------------------------------------------------------------------------
module lbcp_rem_stage #(
  parameter int TIME_BITS = lbcp_pkg::TIME_BITS_DEF,
  parameter int BIT_HI    = lbcp_pkg::TIME_BITS_DEF - 1,
  parameter int STEPS     = lbcp_pkg::REM_STEPS
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [TIME_BITS-1:0] now_i,
  input  lbcp_pkg::ctl_t       ctl_i,
  output logic [TIME_BITS-1:0] now_o,
  output lbcp_pkg::ctl_t       ctl_o
);

  lbcp_pkg::ctl_t ctl_nxt;

  always_comb begin
    logic [lbcp_pkg::SPAN_W-1:0] r;
    logic [lbcp_pkg::SPAN_W:0]   t;
    ctl_nxt = ctl_i;
    r = ctl_i.rem;
    for (int k = 0; k < STEPS; k++) begin
      t = {r, now_i[BIT_HI-k]};
      if (t >= {1'b0, ctl_i.cycle}) begin
        t = t - {1'b0, ctl_i.cycle};
      end
      r = t[lbcp_pkg::SPAN_W-1:0];
    end
    ctl_nxt.rem = r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_o <= ctl_nxt;
      now_o <= now_i;
    end
  end

endmodule

FILE: design/led_blink_code_pattern_unit.sv
// ----------------------------------------------------------------------------
// led_blink_code_pattern_unit
// Status lamp blink-code generator: lamp level from timestamp, drive state
// and fault code.
// ----------------------------------------------------------------------------
// channel  | dir | handshake    | payload
// in_ch    | in  | valid/ready  | now_ms[31:0], drive_state[2:0], fault_code[4:0]
// out_ch   | out | valid/ready  | lamp_on
// cfg_*    | in  | cfg_we       | cfg_addr[1:0], cfg_wdata[15:0]
//
// One item per cycle while out_ch is not stalled. The stages are decode, blip
// span multiply, the remainder stages (up to 4 timestamp bits each), then the
// slot remainder and output register.
// rst_n is synchronous; it empties the pipeline and loads register defaults.
// Each stage holds only while the stage after it is full and held, so a
// stalled output still lets bubbles fill behind it.
// ----------------------------------------------------------------------------
module led_blink_code_pattern_unit #(
  parameter int TIME_BITS = lbcp_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lbcp_in_if.sink                         in_ch,
  lbcp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lbcp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lbcp_pkg::MS_W-1:0]       cfg_wdata
);

  localparam int NRS = (TIME_BITS + lbcp_pkg::REM_STEPS - 1) / lbcp_pkg::REM_STEPS;
  localparam int NST = NRS + 2;

  logic [lbcp_pkg::MS_W-1:0] blip_on_r;
  logic [lbcp_pkg::MS_W-1:0] blip_off_r;
  logic [lbcp_pkg::MS_W-1:0] gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blip_on_r  <= lbcp_pkg::BLIP_ON_RST;
      blip_off_r <= lbcp_pkg::BLIP_OFF_RST;
      gap_r      <= lbcp_pkg::GAP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        lbcp_pkg::CFG_BLIP_ON:  blip_on_r  <= cfg_wdata;
        lbcp_pkg::CFG_BLIP_OFF: blip_off_r <= cfg_wdata;
        lbcp_pkg::CFG_GAP:      gap_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline state
  logic [NST-1:0]       v_r;
  logic [NST:0]         ld;
  lbcp_pkg::ctl_t       ctl_r [NST];
  logic [TIME_BITS-1:0] now_r [NST];
  logic                 out_valid_r;
  logic                 lamp_r;

  assign ld[NST] = !out_valid_r || out_ch.ready;
  for (genvar k = 0; k < NST; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end

  assign in_ch.ready    = ld[0];
  assign out_ch.valid   = out_valid_r;
  assign out_ch.lamp_on = lamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (ld[NST]) begin
        out_valid_r <= v_r[NST-1];
      end
    end
  end

  // stage 0: decode
  logic [TIME_BITS-1:0] now_tb;
  lbcp_pkg::ctl_t       ctl0_nxt;

  if (TIME_BITS <= lbcp_pkg::NOW_W) begin : g_now_cut
    assign now_tb = in_ch.now_ms[TIME_BITS-1:0];
  end else begin : g_now_ext
    assign now_tb = {{(TIME_BITS - lbcp_pkg::NOW_W){1'b0}}, in_ch.now_ms};
  end

  always_comb begin
    ctl0_nxt          = '0;
    ctl0_nxt.on_ms    = blip_on_r;
    ctl0_nxt.gap_ms   = gap_r;
    ctl0_nxt.slot     = {1'b0, blip_on_r} + {1'b0, blip_off_r};
    case (in_ch.drive_state)
      lbcp_pkg::ST_INIT: begin
        ctl0_nxt.force_on = 1'b1;
      end
      lbcp_pkg::ST_SELFTEST: begin
        ctl0_nxt.force_on = 1'b0;
      end
      lbcp_pkg::ST_READY: begin
        ctl0_nxt.pattern = 1'b1;
        ctl0_nxt.blips   = lbcp_pkg::BLIPS_ONE;
      end
      lbcp_pkg::ST_RUN: begin
        ctl0_nxt.pattern = 1'b1;
        ctl0_nxt.blips   = lbcp_pkg::BLIPS_TWO;
      end
      default: begin
        ctl0_nxt.pattern = 1'b1;
        ctl0_nxt.blips   = (in_ch.fault_code == '0) ? lbcp_pkg::BLIPS_ONE
                                                    : in_ch.fault_code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ctl_r[0] <= ctl0_nxt;
      now_r[0] <= now_tb;
    end
  end

  // stage 1: lit span and cycle length
  lbcp_pkg::ctl_t ctl1_nxt;
  logic [lbcp_pkg::SPAN_W:0] cycle_sum;

  always_comb begin
    ctl1_nxt          = ctl_r[0];
    ctl1_nxt.lit_span = lbcp_pkg::SPAN_W'(ctl_r[0].blips) *
                        lbcp_pkg::SPAN_W'(ctl_r[0].slot);
    cycle_sum         = {1'b0, ctl1_nxt.lit_span} +
                        (lbcp_pkg::SPAN_W + 1)'(ctl_r[0].gap_ms);
    ctl1_nxt.cycle    = cycle_sum[lbcp_pkg::SPAN_W-1:0];
    ctl1_nxt.rem      = '0;
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ctl_r[1] <= ctl1_nxt;
      now_r[1] <= now_r[0];
    end
  end

  // stages 2 .. NRS+1: timestamp remainder by cycle length
  for (genvar s = 0; s < NRS; s++) begin : g_rem
    localparam int HI    = TIME_BITS - 1 - s * lbcp_pkg::REM_STEPS;
    localparam int STEPS = (HI + 1 < lbcp_pkg::REM_STEPS) ? HI + 1 : lbcp_pkg::REM_STEPS;

    lbcp_rem_stage #(
      .TIME_BITS (TIME_BITS),
      .BIT_HI    (HI),
      .STEPS     (STEPS)
    ) u_rem (
      .clk   (clk),
      .load  (ld[s+2]),
      .now_i (now_r[s+1]),
      .ctl_i (ctl_r[s+1]),
      .now_o (now_r[s+2]),
      .ctl_o (ctl_r[s+2])
    );
  end

  // final stage: position within blip slot
  logic lamp_nxt;

  always_comb begin
    logic [lbcp_pkg::SPAN_W-1:0] r;
    logic [lbcp_pkg::SPAN_W-1:0] d;
    logic                        in_span;
    r       = ctl_r[NST-1].rem;
    in_span = ctl_r[NST-1].rem < ctl_r[NST-1].lit_span;
    for (int k = lbcp_pkg::BLIP_W - 1; k >= 0; k--) begin
      d = lbcp_pkg::SPAN_W'(ctl_r[NST-1].slot) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    lamp_nxt = ctl_r[NST-1].force_on ||
               (ctl_r[NST-1].pattern && (ctl_r[NST-1].cycle != '0) && in_span &&
                (r < lbcp_pkg::SPAN_W'(ctl_r[NST-1].on_ms)));
  end

  always_ff @(posedge clk) begin
    if (ld[NST]) begin
      lamp_r <= lamp_nxt;
    end
  end

endmodule

FILE: design/lbcp_checker.sv
// ----------------------------------------------------------------------------
// lbcp_checker
// Port-level checks for the blink-code unit, bound to the top level.
// ----------------------------------------------------------------------------
module lbcp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_lamp_on
);

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_lamp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_lamp_on))
    else $error("result changed while stalled");

endmodule

bind led_blink_code_pattern_unit lbcp_checker u_lbcp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_lamp_on (out_ch.lamp_on)
);
